// ===== rtl/core/logm_pkg.sv =====
// Package for the lidar occupancy grid marker: shared constants and types.
// Holds op codes, the CORDIC arctangent table and the CORDIC unit request type.
// No dependencies.
`default_nettype none
package logm_pkg;

  localparam logic [1:0] OP_POSE = 2'd0;
  localparam logic [1:0] OP_BEAM = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] REG_SCALE     = 3'd0;
  localparam logic [2:0] REG_WIDTH     = 3'd1;
  localparam logic [2:0] REG_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_RANGE_MIN = 3'd3;
  localparam logic [2:0] REG_RANGE_MAX = 3'd4;
  localparam logic [2:0] REG_ANG_START = 3'd5;
  localparam logic [2:0] REG_ANG_STEP  = 3'd6;

  localparam int CW = 36;  // CORDIC datapath width, Q2.30 plus headroom
  localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic             start;
    logic             vect;   // 1 vectoring (atan2), 0 rotation (cos/sin)
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [32:0]   z;
  } cordic_req_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/logm_cordic.sv =====
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on logm_pkg.
`default_nettype none
module logm_cordic
  import logm_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cordic_req_t req,
  output logic             done,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic [31:0]      z_out
);
  logic signed [CW-1:0] x, y;
  logic signed [32:0] z;
  logic [4:0] step;
  logic busy, vect;
  logic signed [CW-1:0] dx, dy;
  logic [32:0] a;
  logic go_pos, go_neg;

  always_comb begin
    dx = y >>> step;
    dy = x >>> step;
    a  = {1'b0, atan_entry(step)};
    if (vect) begin
      go_pos = (y > 0);
      go_neg = (y < 0);
    end else begin
      go_pos = !z[32];
      go_neg = z[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        vect <= req.vect;
        x <= req.x;
        y <= req.y;
        z <= req.z;
      end else if (busy) begin
        if (vect ? go_pos : go_pos) begin
          if (vect) begin
            x <= x + dx; y <= y - dy; z <= z + $signed(a);
          end else begin
            x <= x - dx; y <= y + dy; z <= z - $signed(a);
          end
        end else if (go_neg) begin
          if (vect) begin
            x <= x - dx; y <= y + dy; z <= z - $signed(a);
          end else begin
            x <= x + dx; y <= y - dy; z <= z + $signed(a);
          end
        end
        if (step == 5'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z[31:0];
endmodule
`default_nettype wire

// ===== rtl/core/lidar_occupancy_grid_marker.sv =====
// Lidar occupancy grid marker: pose / beam / read requests on an occupancy map.
// One request at a time; the next is taken the cycle after its result is registered.
// Reset clears the map with a pass over all MAX_GRID_W*MAX_GRID_H cells, one cell per
// cycle, during which no request is accepted; configuration writes go on.
// Depends on logm_pkg and logm_cordic.
`default_nettype none
module lidar_occupancy_grid_marker
  import logm_pkg::*;
#(
  parameter int MAX_GRID_W   = 64,
  parameter int MAX_GRID_H   = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic signed [20:0] pos_x_mm,
  input  wire logic signed [20:0] pos_y_mm,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic [15:0] range_mm,
  input  wire logic        first_beam,
  input  wire logic [11:0] read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic             cell_marked,
  output logic [5:0]       cell_col,
  output logic [5:0]       cell_row,
  output logic signed [7:0] cell_value
);
  localparam int NCELLS = MAX_GRID_W * MAX_GRID_H;
  localparam int AW = $clog2(NCELLS);
  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int GWW = $clog2(MAX_GRID_W + 1);
  localparam int GHW = $clog2(MAX_GRID_H + 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PQ1   = 4'd2;  // quaternion products
  localparam logic [3:0] S_PQ2   = 4'd3;  // numerator / denominator, start CORDIC
  localparam logic [3:0] S_PCOR  = 4'd4;
  localparam logic [3:0] S_BCOR  = 4'd5;
  localparam logic [3:0] S_BMUL1 = 4'd6;  // range * cos / sin
  localparam logic [3:0] S_BMUL2 = 4'd7;  // q14 position
  localparam logic [3:0] S_BMUL3 = 4'd8;  // times scale
  localparam logic [3:0] S_BMUL4 = 4'd9;  // truncate toward zero
  localparam logic [3:0] S_BIDX  = 4'd10; // row * width + col, write
  localparam logic [3:0] S_RD1   = 4'd11; // memory read issued
  localparam logic [3:0] S_RD2   = 4'd12; // data back
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;

  // configuration
  logic [15:0] scale, rmin, rmax, ang_start, ang_step;
  logic [6:0]  gw_reg, gh_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= 16'd655; gw_reg <= 7'd64; gh_reg <= 7'd64;
      rmin <= 16'd0; rmax <= 16'hFFFF; ang_start <= 16'd0; ang_step <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:     scale     <= cfg_data;
        REG_WIDTH:     gw_reg    <= cfg_data[6:0];
        REG_HEIGHT:    gh_reg    <= cfg_data[6:0];
        REG_RANGE_MIN: rmin      <= cfg_data;
        REG_RANGE_MAX: rmax      <= cfg_data;
        REG_ANG_START: ang_start <= cfg_data;
        REG_ANG_STEP:  ang_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the built grid size
  logic [GWW-1:0] gw;
  logic [GHW-1:0] gh;
  always_comb begin
    if ({25'd0, gw_reg} > MAX_GRID_W) gw = GWW'(MAX_GRID_W);
    else gw = GWW'(gw_reg);
    if ({25'd0, gh_reg} > MAX_GRID_H) gh = GHW'(MAX_GRID_H);
    else gh = GHW'(gh_reg);
  end

  // occupancy memory, one bit per cell
  logic mem [NCELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= (state != S_CLEAR);
    mem_rdata <= mem[mem_raddr];
  end

  // pose state
  logic signed [20:0] robot_x, robot_y;
  logic [15:0] robot_yaw, beam_angle;

  // request holding
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [20:0] px, py;
  logic [15:0] rng;
  logic [11:0] ridx;
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [CW-1:0] num_s, den_c;

  // CORDIC
  cordic_req_t creq;
  logic cdone;
  logic signed [CW-1:0] cx, cy;
  logic [31:0] cz;
  logic flip;

  logm_cordic #(.STEPS(STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(creq), .done(cdone),
    .x_out(cx), .y_out(cy), .z_out(cz)
  );

  // beam datapath
  logic signed [CW-1:0] co, si;
  logic signed [52:0] offx, offy;       // range * cos, Q30 mm
  logic signed [40:0] q14x, q14y;       // Q14 mm
  logic signed [57:0] prodx, prody;     // q14 * scale
  logic signed [28:0] gx, gy;
  logic [AW-1:0] clr_addr;
  logic marked;

  // result register
  logic [1:0] res_kind;
  logic res_marked;
  logic [5:0] res_col, res_row;
  logic signed [7:0] res_val;

  assign in_stall = (state != S_IDLE);
  wire in_acc = in_valid && !in_stall;

  wire [15:0] beam_ang_now = first_beam ? ang_start : beam_angle;
  wire [15:0] rot_ang = robot_yaw + beam_angle;

  // rotation angle with half-turn fold
  logic signed [32:0] rot_z;
  logic rot_flip;
  logic cbusy_started;
  always_comb begin
    logic signed [32:0] z0;
    z0 = {rot_ang[15], rot_ang, 16'd0};
    rot_flip = (z0 > 33'sd1073741824) || (z0 < -33'sd1073741824);
    if (rot_flip) rot_z = (z0 > 0) ? z0 - 33'sh0_8000_0000 : z0 + 33'sh0_8000_0000;
    else rot_z = z0;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = clr_addr;
    mem_raddr = AW'(ridx);
    creq = '0;
    if (state == S_CLEAR) mem_we = 1'b1;
    if (state == S_BIDX && marked) begin
      mem_we = 1'b1;
      mem_waddr = AW'(gy * $signed({1'b0, gw}) + gx);
    end
    if (state == S_PQ2) begin
      creq.start = 1'b1;
      creq.vect = 1'b1;
      creq.x = den_c[CW-1] ? -den_c : den_c;
      creq.y = den_c[CW-1] ? -num_s : num_s;
      creq.z = den_c[CW-1] ? 33'sh0_8000_0000 : 33'sd0;
    end
    if (state == S_BCOR && !cbusy_started) begin
      creq.start = 1'b1;
      creq.vect = 1'b0;
      creq.x = GAIN_Q30;
      creq.y = '0;
      creq.z = rot_z;
    end
  end

  wire in_range = (rng >= rmin) && (rng <= rmax);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      robot_x <= 21'sd1000;
      robot_y <= 21'sd1000;
      robot_yaw <= '0;
      beam_angle <= '0;
      cbusy_started <= 1'b0;
    end else begin
      // raise valid when a result is registered, drop it once taken
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NCELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            qw <= quat_w; qx <= quat_x; qy <= quat_y; qz <= quat_z;
            px <= pos_x_mm; py <= pos_y_mm; rng <= range_mm; ridx <= read_index;
            res_kind <= op; res_marked <= 1'b0; res_col <= '0; res_row <= '0;
            res_val <= '0;
            priority case (op)
              OP_POSE: state <= S_PQ1;
              OP_BEAM: begin
                beam_angle <= beam_ang_now;
                cbusy_started <= 1'b0;
                state <= S_BCOR;
              end
              OP_READ: state <= S_RD1;
              default: state <= S_OUT;
            endcase
          end
        end
        S_PQ1: begin
          p_wz <= qw * qz; p_xy <= qx * qy; p_yy <= qy * qy; p_zz <= qz * qz;
          state <= S_PQ2;
        end
        S_PQ2: begin
          state <= S_PCOR;
        end
        S_PCOR: begin
          if (cdone) begin
            robot_x <= px; robot_y <= py;
            robot_yaw <= 16'((cz + 32'h8000) >> 16);
            state <= S_OUT;
          end
        end
        S_BCOR: begin
          if (!in_range) begin
            beam_angle <= beam_angle + ang_step;
            state <= S_OUT;
          end else if (!cbusy_started) begin
            cbusy_started <= 1'b1;
            flip <= rot_flip;
          end else if (cdone) begin
            co <= flip ? -cx : cx;
            si <= flip ? -cy : cy;
            beam_angle <= beam_angle + ang_step;
            state <= S_BMUL1;
          end
        end
        S_BMUL1: begin
          offx <= $signed({1'b0, rng}) * co;
          offy <= $signed({1'b0, rng}) * si;
          state <= S_BMUL2;
        end
        S_BMUL2: begin
          q14x <= 41'(robot_x * 41'sd16384) + 41'(offx >>> 16);
          q14y <= 41'(robot_y * 41'sd16384) + 41'(offy >>> 16);
          state <= S_BMUL3;
        end
        S_BMUL3: begin
          prodx <= q14x * $signed({1'b0, scale});
          prody <= q14y * $signed({1'b0, scale});
          state <= S_BMUL4;
        end
        S_BMUL4: begin
          // truncate toward zero: bias negatives by 2^30-1
          gx <= 29'((prodx + (prodx[57] ? 58'sd1073741823 : 58'sd0)) >>> 30);
          gy <= 29'((prody + (prody[57] ? 58'sd1073741823 : 58'sd0)) >>> 30);
          state <= S_BIDX;
        end
        S_BIDX: begin
          res_marked <= marked;
          res_col <= marked ? gx[5:0] : 6'd0;
          res_row <= marked ? gy[5:0] : 6'd0;
          state <= S_OUT;
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          res_val <= (({20'd0, ridx} < 32'(gw) * 32'(gh)) && mem_rdata) ? 8'sd100 : -8'sd1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    num_s = CW'(2 * (36'(p_wz) + 36'(p_xy)));
    den_c = 36'sd1073741824 - CW'(2 * (36'(p_yy) + 36'(p_zz)));
    marked = !gx[28] && !gy[28] && (gx < $signed({1'b0, gw})) &&
             (gy < $signed({1'b0, gh}));
  end

  // output register
  logic [1:0] o_kind; logic o_marked; logic [5:0] o_col, o_row; logic signed [7:0] o_val;
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      o_kind <= res_kind; o_marked <= res_marked; o_col <= res_col;
      o_row <= res_row; o_val <= res_val;
    end
  end
  assign result_kind = o_kind;
  assign cell_marked = o_marked;
  assign cell_col = o_col;
  assign cell_row = o_row;
  assign cell_value = o_val;
endmodule
`default_nettype wire

// ===== rtl/core/logm_checker.sv =====
// Port-level checker for the lidar occupancy grid marker, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module logm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [1:0] result_kind,
  input wire logic cell_marked,
  input wire logic signed [7:0] cell_value
);
  // a held result keeps its kind
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind))
    else $error("result changed while stalled");
  // only beams mark cells
  a_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_marked |-> result_kind == 2'd1)
    else $error("mark on non-beam result");
  // reads answer -1 or 100
  a_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == 2'd2 |-> cell_value == 8'sd100 || cell_value == -8'sd1)
    else $error("bad read value");
  // one request in flight: accept blocks the input next cycle
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while busy");
endmodule

bind lidar_occupancy_grid_marker logm_checker u_logm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
  .cell_marked(cell_marked), .cell_value(cell_value)
);
`default_nettype wire
